/* sv/rrp_pkg.sv */
// Package for the rate-limited round-robin picker.
// Holds sizes, request and status codes, sequencer states and the per-kind limit tables.
// No dependencies.
`default_nettype none

package rrp_pkg;

   localparam int NUM_TASKS  = 15;
   localparam int NUM_SLOTS  = 8;
   localparam int KIND_W     = 4;
   localparam int SLOT_IDX_W = 3;
   localparam int CFG_W      = 4;
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int PROBE_W    = $clog2(NUM_TASKS);
   localparam int TIME_W     = 32;
   localparam int LIMIT_W    = 2;

   typedef enum logic [1:0] {
      REQ_PICK       = 2'd0,
      REQ_WRITE_SLOT = 2'd1,
      REQ_STAMP      = 2'd2,
      REQ_UNUSED     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_SLOTS_FULL    = 2'd1,
      ST_NONE_ELIGIBLE = 2'd2,
      ST_BAD_INDEX     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_PROBE,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic                  slot_we;
      logic [SLOT_IDX_W-1:0] slot_idx;
      logic                  slot_busy;
      logic [KIND_W-1:0]     slot_kind;
      logic                  stamp_we;
      logic [KIND_W-1:0]     stamp_kind;
      logic [TIME_W-1:0]     stamp_time;
   } tbl_wr_type;

   typedef struct packed {
      logic slots_full;
      logic eligible;
   } probe_res_type;

   function automatic logic [LIMIT_W-1:0] task_limit(input logic [KIND_W-1:0] kind);
      logic [LIMIT_W-1:0] lim;
      case (kind)
         4'd7: begin
            lim = 2'd2;
         end
         default: begin
            lim = 2'd1;
         end
      endcase
      return lim;
   endfunction

   function automatic logic [TIME_W-1:0] task_interval(input logic [KIND_W-1:0] kind);
      logic [TIME_W-1:0] ivl;
      case (kind)
         4'd4:    ivl = 32'd120;
         4'd9:    ivl = 32'd7200;
         4'd10:   ivl = 32'd3600;
         4'd11:   ivl = 32'd7200;
         4'd12:   ivl = 32'd120;
         4'd13:   ivl = 32'd7200;
         4'd14:   ivl = 32'd600;
         default: ivl = 32'd0;
      endcase
      return ivl;
   endfunction

endpackage

`default_nettype wire

/* sv/rrp_tables.sv */
// Worker slot table and per-kind last-run time table of the picker.
// Depends on rrp_pkg for sizes and the write command struct.
`default_nettype none

module rrp_tables (
   input  wire                        clock,
   input  wire                        reset,
   input  rrp_pkg::tbl_wr_type        wr,
   input  wire [rrp_pkg::KIND_W-1:0]  rd_kind,
   output logic [rrp_pkg::NUM_SLOTS-1:0] slot_valid,
   output logic [rrp_pkg::KIND_W-1:0] slot_task [rrp_pkg::NUM_SLOTS],
   output logic [rrp_pkg::TIME_W-1:0] rd_last_run
);
   import rrp_pkg::*;

   logic [NUM_SLOTS-1:0] slot_valid_ff;
   logic [KIND_W-1:0]    slot_task_ff [NUM_SLOTS];
   logic [TIME_W-1:0]    last_run_ff  [NUM_TASKS];

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (wr.slot_we) begin
         slot_valid_ff[wr.slot_idx] <= wr.slot_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.slot_we) begin
         slot_task_ff[wr.slot_idx] <= wr.slot_busy ? wr.slot_kind : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            last_run_ff[i] <= '0;
         end
      end else if (wr.stamp_we) begin
         last_run_ff[wr.stamp_kind] <= wr.stamp_time;
      end
   end

   assign slot_valid  = slot_valid_ff;
   assign slot_task   = slot_task_ff;
   assign rd_last_run = last_run_ff[rd_kind];

endmodule

`default_nettype wire

/* sv/rrp_probe.sv */
// Shared eligibility unit: slot occupancy check and one task-kind probe per cycle.
// Depends on rrp_pkg for sizes, limit tables and the result struct.
`default_nettype none

module rrp_probe (
   input  wire [rrp_pkg::CFG_W-1:0]      max_slots,
   input  wire [rrp_pkg::NUM_SLOTS-1:0]  slot_valid,
   input  wire [rrp_pkg::KIND_W-1:0]     slot_task [rrp_pkg::NUM_SLOTS],
   input  wire [rrp_pkg::KIND_W-1:0]     kind,
   input  wire [rrp_pkg::TIME_W-1:0]     last_run,
   input  wire [rrp_pkg::TIME_W-1:0]     now,
   output rrp_pkg::probe_res_type        res
);
   import rrp_pkg::*;

   logic [CNT_W-1:0]  busy;
   logic [CNT_W-1:0]  running;
   logic [TIME_W:0]   due_time;

   always_comb begin
      busy    = '0;
      running = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if ((CFG_W'(i) < max_slots) && slot_valid[i]) begin
            busy = busy + CNT_W'(1);
            if (slot_task[i] == kind) begin
               running = running + CNT_W'(1);
            end
         end
      end
   end

   assign due_time = {1'b0, last_run} + {1'b0, task_interval(kind)};

   always_comb begin
      res.slots_full = ({1'b0, busy} + (CNT_W + 1)'(1)) >= {1'b0, max_slots};
      res.eligible   = (running < CNT_W'(task_limit(kind))) && (due_time <= {1'b0, now});
   end

endmodule

`default_nettype wire

/* sv/rrp_seq.sv */
// Sequencer of the picker: request decode, probe loop, round-robin pointer,
// configuration register and the result register. Depends on rrp_pkg.
`default_nettype none

module rrp_seq (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [1:0]                    req_type,
   input  wire [rrp_pkg::SLOT_IDX_W-1:0] req_slot_index,
   input  wire                          req_slot_busy,
   input  wire [rrp_pkg::KIND_W-1:0]    req_step_id,
   input  wire [rrp_pkg::TIME_W-1:0]    req_current_time,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [rrp_pkg::KIND_W-1:0]   rsp_chosen_step,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [rrp_pkg::CFG_W-1:0]     csr_slots_in_use,
   input  rrp_pkg::probe_res_type       probe,
   output logic [rrp_pkg::CFG_W-1:0]    max_slots,
   output logic [rrp_pkg::KIND_W-1:0]   probe_kind,
   output logic [rrp_pkg::TIME_W-1:0]   probe_time,
   output rrp_pkg::tbl_wr_type          wr
);
   import rrp_pkg::*;

   seq_state_type        state_ff, state_in;
   logic [CFG_W-1:0]     slots_ff;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [PROBE_W-1:0]   count_ff, count_in;
   logic [KIND_W-1:0]    ptr_ff, ptr_in;
   status_type           res_status_ff, res_status_in;
   logic [KIND_W-1:0]    res_chosen_ff, res_chosen_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [KIND_W-1:0]    rsp_chosen_ff;

   logic                 accept;
   logic                 out_free;
   logic                 kind_ok;
   logic                 slot_ok;
   logic [KIND_W-1:0]    ptr_next;

   assign accept    = req_valid && (state_ff == SEQ_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign kind_ok   = req_step_id < KIND_W'(NUM_TASKS);
   assign slot_ok   = {1'b0, req_slot_index} < (SLOT_IDX_W + 1)'(NUM_SLOTS);
   assign ptr_next  = (ptr_ff == KIND_W'(NUM_TASKS - 1)) ? '0 : ptr_ff + KIND_W'(1);
   assign max_slots = (slots_ff > CFG_W'(NUM_SLOTS)) ? CFG_W'(NUM_SLOTS) : slots_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = (req_type == REQ_PICK) ? SEQ_CHECK : SEQ_DONE;
            end
         end
         SEQ_CHECK: begin
            state_in = probe.slots_full ? SEQ_DONE : SEQ_PROBE;
         end
         SEQ_PROBE: begin
            if (probe.eligible || (count_ff == PROBE_W'(NUM_TASKS - 1))) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      time_in       = time_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_chosen_in = res_chosen_ff;
      wr            = '0;
      wr.slot_idx   = req_slot_index;
      wr.slot_busy  = req_slot_busy;
      wr.slot_kind  = req_step_id;
      wr.stamp_kind = req_step_id;
      wr.stamp_time = req_current_time;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               time_in       = req_current_time;
               res_status_in = ST_OK;
               res_chosen_in = '0;
               case (req_type)
                  REQ_WRITE_SLOT: begin
                     if (slot_ok) begin
                        if (!req_slot_busy || kind_ok) begin
                           wr.slot_we = 1'b1;
                        end else begin
                           res_status_in = ST_BAD_INDEX;
                        end
                     end
                  end
                  REQ_STAMP: begin
                     if (kind_ok) begin
                        wr.stamp_we = 1'b1;
                     end else begin
                        res_status_in = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_CHECK: begin
            count_in = '0;
            if (probe.slots_full) begin
               res_status_in = ST_SLOTS_FULL;
            end
         end
         SEQ_PROBE: begin
            ptr_in   = ptr_next;
            count_in = count_ff + PROBE_W'(1);
            if (probe.eligible) begin
               res_status_in = ST_OK;
               res_chosen_in = ptr_ff;
            end else if (count_ff == PROBE_W'(NUM_TASKS - 1)) begin
               res_status_in = ST_NONE_ELIGIBLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == SEQ_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         ptr_ff       <= '0;
         slots_ff     <= CFG_W'(NUM_SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            slots_ff <= csr_slots_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_chosen_ff <= res_chosen_in;
      if ((state_ff == SEQ_DONE) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_chosen_ff <= res_chosen_ff;
      end
   end

   assign req_stall       = (state_ff != SEQ_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_step = rsp_chosen_ff;
   assign probe_kind      = ptr_ff;
   assign probe_time      = time_ff;

endmodule

`default_nettype wire

/* sv/rate_limited_round_robin_picker_top.sv */
// Top level of the rate-limited round-robin picker.
// Instantiates rrp_seq, rrp_tables and rrp_probe; depends on rrp_pkg.
//
// Each transaction on the req_ channel yields exactly one transaction on the rsp_
// channel. A slot write, a stamp or an unused request goes from acceptance to the
// DONE state, which loads its result into the output register. A pick goes from
// CHECK to PROBE, where it probes k task kinds (1 to 15), before DONE loads its
// result; a pick refused because the slots are full goes from CHECK to DONE.
// The probe loop runs one task kind per cycle through a single shared eligibility
// unit. The block takes one request at a time and holds req_stall high until the
// result has moved to the output register, which may still hold an earlier result
// waiting to be taken; DONE waits while rsp_stall holds that result back. The next
// request can be accepted in the cycle after the move. The slots_in_use register
// resets to 8 and is written through csr_valid; csr_ready is always high, and the
// register should be written only while no request is in flight.
`default_nettype none

module rate_limited_round_robin_picker_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [1:0]  req_type,
   input  wire [2:0]  req_slot_index,
   input  wire        req_slot_busy,
   input  wire [3:0]  req_step_id,
   input  wire [31:0] req_current_time,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_chosen_step,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [3:0]  csr_slots_in_use
);
   import rrp_pkg::*;

   probe_res_type        probe;
   tbl_wr_type           wr;
   logic [CFG_W-1:0]     max_slots;
   logic [KIND_W-1:0]    probe_kind;
   logic [TIME_W-1:0]    probe_time;
   logic [TIME_W-1:0]    last_run;
   logic [NUM_SLOTS-1:0] slot_valid;
   logic [KIND_W-1:0]    slot_task [NUM_SLOTS];

   rrp_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_slot_index   (req_slot_index),
      .req_slot_busy    (req_slot_busy),
      .req_step_id      (req_step_id),
      .req_current_time (req_current_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_chosen_step  (rsp_chosen_step),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use),
      .probe            (probe),
      .max_slots        (max_slots),
      .probe_kind       (probe_kind),
      .probe_time       (probe_time),
      .wr               (wr)
   );

   rrp_tables u_tables (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .rd_kind     (probe_kind),
      .slot_valid  (slot_valid),
      .slot_task   (slot_task),
      .rd_last_run (last_run)
   );

   rrp_probe u_probe (
      .max_slots  (max_slots),
      .slot_valid (slot_valid),
      .slot_task  (slot_task),
      .kind       (probe_kind),
      .last_run   (last_run),
      .now        (probe_time),
      .res        (probe)
   );

endmodule

`default_nettype wire

/* sv/rrp_checker.sv */
// Port-level checker for the picker top level, with its bind statement.
// Depends on rrp_pkg for status codes and the number of task kinds.
`default_nettype none

module rrp_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [1:0] rsp_status,
   input wire [3:0] rsp_chosen_step
);
   import rrp_pkg::*;

   // A result held back by the consumer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_chosen_step))
      else $error("stalled response changed");

   // Only one request is in flight: acceptance closes the input until it completes.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another was in flight");

   // Any result other than a grant carries no task kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_chosen_step == 4'd0))
      else $error("chosen step set on a non-grant response");

   // A granted kind lies inside the task table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> (rsp_chosen_step < 4'(NUM_TASKS)))
      else $error("chosen step out of range");

endmodule

bind rate_limited_round_robin_picker_top rrp_checker u_rrp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_chosen_step (rsp_chosen_step)
);

`default_nettype wire
